/* hw/rtl/msf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msf_pkg
// Shared types and constants for the spanning forest leftover weight block.
// ----------------------------------------------------------------------------
package msf_pkg;

    localparam int unsigned MaxNodesDef   = 1024;
    localparam int unsigned MaxEdgesDef   = 4096;
    localparam int unsigned WeightBitsDef = 16;

    localparam int unsigned NodeW  = 11;
    localparam int unsigned InWgtW = 16;
    localparam int unsigned TotalW = 28;
    localparam logic [TotalW-1:0] TotalMax = '1;
    localparam logic [NodeW-1:0]  NodeCountRst = 11'd1024;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CLR,
        ST_SINIT,
        ST_MRD,
        ST_MRDW,
        ST_MCMP,
        ST_MWR,
        ST_MNEXT,
        ST_KRD,
        ST_KRDW,
        ST_KEDGE,
        ST_FRD,
        ST_FWAIT,
        ST_FCHK,
        ST_CRD,
        ST_CWAIT,
        ST_CWR,
        ST_JOIN,
        ST_SZRD,
        ST_SZWAIT,
        ST_SZWR,
        ST_OUT
    } t_state;

endpackage : msf_pkg
`default_nettype wire

/* hw/rtl/max_spanning_forest_leftover_weight.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// max_spanning_forest_leftover_weight
// Stores edges, merge-sorts them by descending weight, runs Kruskal with a
// union-find held in memory, and emits the weight left outside the forest.
// ----------------------------------------------------------------------------
// Loading: one edge item per cycle while no graph is being processed and no
// result is waiting. After the last edge: node table clear, order init, merge
// sort (ceil(log2(edges)) passes), then Kruskal: an edge fetch, parent
// accesses in find and compression, then counting a leftover edge or joining
// two sets.
// Result holds in an output register until taken; then the next graph loads.
// Reset is synchronous, active low; node_count resets to 1024.
module max_spanning_forest_leftover_weight
    import msf_pkg::*;
#(
    parameter int unsigned MAX_NODES   = MaxNodesDef,
    parameter int unsigned MAX_EDGES   = MaxEdgesDef,
    parameter int unsigned WEIGHT_BITS = WeightBitsDef
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [NodeW-1:0]       i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // node_a [10:0], node_b [21:11], weight [37:22], zero fill [39:38]
    input  wire logic [39:0]            s_axis_tdata,
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // leftover_weight [27:0], zero fill [31:28]
    output logic [31:0]                 m_axis_tdata
);

    localparam int unsigned NB  = $clog2(MAX_NODES + 1);
    localparam int unsigned EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned EC  = $clog2(MAX_EDGES + 1);
    localparam int unsigned WB  = WEIGHT_BITS;
    localparam int unsigned EW  = 2 * NodeW + WB;
    localparam int unsigned CB  = NB + 1;
    localparam logic [EC-1:0] MaxEdgesC = EC'(MAX_EDGES);

    // ---------------- memories ----------------
    logic [EW-1:0] r_edge_mem [MAX_EDGES];
    logic [EA-1:0] r_ord_mem  [2*MAX_EDGES];
    logic [NB-1:0] r_par_mem  [MAX_NODES+1];
    logic [CB-1:0] r_sz_mem   [MAX_NODES+1];

    logic          e_we;
    logic [EA-1:0] e_wa, e_ra;
    logic [EW-1:0] e_wd, e_rd;
    logic          o_we;
    logic [EA:0]   o_wa, o_ra;
    logic [EA-1:0] o_wd, o_rd;
    logic          p_we;
    logic [NB-1:0] p_wa, p_ra, p_wd, p_rd;
    logic          z_we;
    logic [NB-1:0] z_wa, z_ra;
    logic [CB-1:0] z_wd, z_rd;

    always_ff @(posedge i_clk) begin
        if (e_we) r_edge_mem[e_wa] <= e_wd;
        e_rd <= r_edge_mem[e_ra];
        if (o_we) r_ord_mem[o_wa] <= o_wd;
        o_rd <= r_ord_mem[o_ra];
        if (p_we) r_par_mem[p_wa] <= p_wd;
        p_rd <= r_par_mem[p_ra];
        if (z_we) r_sz_mem[z_wa] <= z_wd;
        z_rd <= r_sz_mem[z_ra];
    end

    // ---------------- registers ----------------
    t_state        r_state, n_state;
    logic [NodeW-1:0] r_ncnt;
    logic [EC-1:0] r_ecnt, n_ecnt;
    logic [NB-1:0] r_ci, n_ci;          // clear / general node index
    logic [EC-1:0] r_wid, n_wid;        // merge run width
    logic          r_bank, n_bank;      // source bank of order memory
    logic [EC-1:0] r_lo, n_lo, r_i, n_i, r_j, n_j, r_k, n_k;
    logic [EA-1:0] r_xi, n_xi, r_xj, n_xj;
    logic [WB-1:0] r_wi, n_wi;
    logic          r_side, n_side;      // 0: fetching i, 1: fetching j
    logic [NB-1:0] r_ua, n_ua, r_ub, n_ub;
    logic [WB-1:0] r_ew, n_ew;
    logic          r_phb, n_phb;        // finding endpoint b
    logic [NB-1:0] r_cur, n_cur, r_root, n_root, r_ra, n_ra;
    logic          r_comp, n_comp;      // compression pass
    logic [CB-1:0] r_sza, n_sza;
    logic [TotalW:0] r_tot, n_tot;
    logic          r_ov;
    logic [TotalW-1:0] r_res;

    logic [NodeW-1:0] lim;
    assign lim = (32'(r_ncnt) > MAX_NODES) ? NodeW'(MAX_NODES) : r_ncnt;

    function automatic logic [NB-1:0] map_node(input logic [NodeW-1:0] v,
                                              input logic [NodeW-1:0] l);
        map_node = (v != '0 && v <= l) ? NB'(v) : '0;
    endfunction

    logic [EC-1:0] mid, hi, s2;
    logic [EC:0]   t1, t2;
    always_comb begin
        t1  = (EC+1)'(r_lo) + (EC+1)'(r_wid);
        mid = (t1 < (EC+1)'(r_ecnt)) ? EC'(t1) : r_ecnt;
        t2  = (EC+1)'(mid) + (EC+1)'(r_wid);
        hi  = (t2 < (EC+1)'(r_ecnt)) ? EC'(t2) : r_ecnt;
        s2  = EC'((EC+1)'(r_lo) + ((EC+1)'(r_wid) << 1));
    end

    assign o_cfg_ready   = (r_state == ST_LOAD) && !r_ov;
    assign s_axis_tready = (r_state == ST_LOAD) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'd0, r_res};

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state; n_ecnt = r_ecnt; n_ci = r_ci; n_wid = r_wid;
        n_bank = r_bank; n_lo = r_lo; n_i = r_i; n_j = r_j; n_k = r_k;
        n_xi = r_xi; n_xj = r_xj; n_wi = r_wi; n_side = r_side;
        n_ua = r_ua; n_ub = r_ub; n_ew = r_ew; n_phb = r_phb; n_cur = r_cur;
        n_root = r_root; n_ra = r_ra; n_comp = r_comp; n_sza = r_sza;
        n_tot = r_tot;
        e_we = 1'b0; e_wa = EA'(r_ecnt); e_ra = '0;
        e_wd = {s_axis_tdata[22 +: WB], s_axis_tdata[21:11], s_axis_tdata[10:0]};
        o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
        p_we = 1'b0; p_wa = r_ci; p_wd = r_ci; p_ra = r_cur;
        z_we = 1'b0; z_wa = r_ci; z_wd = CB'(1); z_ra = r_ra;
        case (r_state)
            ST_LOAD: begin
                if (s_acc) begin
                    if (r_ecnt < MaxEdgesC) begin
                        e_we   = 1'b1;
                        n_ecnt = r_ecnt + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_CLR;
                        n_ci    = '0;
                    end
                end
            end
            ST_CLR: begin
                p_we = 1'b1; z_we = 1'b1;
                n_ci = r_ci + 1'b1;
                if (32'(r_ci) == MAX_NODES) begin
                    n_state = ST_SINIT;
                    n_k     = '0;
                end
            end
            ST_SINIT: begin
                // identity order into bank 0
                if (r_k == n_ecnt) begin
                    n_state = ST_MNEXT; n_wid = EC'(1); n_bank = 1'b0;
                    n_lo = '0; n_i = '0; n_j = '0;
                end else begin
                    o_we = 1'b1; o_wa = {1'b0, EA'(r_k)}; o_wd = EA'(r_k);
                    n_k = r_k + 1'b1;
                end
                if (r_k == n_ecnt) begin
                    n_k = '0;
                    if (r_wid >= r_ecnt || r_ecnt <= EC'(1)) begin
                        n_wid = EC'(1);
                    end
                    // start merge of the first run pair
                    n_lo = '0;
                    n_state = ST_MNEXT;
                end
            end
            ST_MNEXT: begin
                // begin a run pair, finish a pass, or end the sort
                if (r_wid >= r_ecnt) begin
                    n_state = ST_KRD; n_k = '0;
                end else if (r_lo >= r_ecnt) begin
                    n_lo = '0; n_bank = ~r_bank; n_wid = r_wid << 1;
                end else begin
                    n_i = r_lo; n_j = mid; n_k = r_lo;
                    n_state = ST_MRD; n_side = 1'b0;
                end
            end
            ST_MRD: begin
                if (r_i < mid && r_j < hi) begin
                    o_ra = r_side ? {r_bank, EA'(r_j)} : {r_bank, EA'(r_i)};
                    n_state = ST_MRDW;
                end else if (r_i < mid || r_j < hi) begin
                    o_ra = (r_i < mid) ? {r_bank, EA'(r_i)} : {r_bank, EA'(r_j)};
                    n_side = (r_i < mid) ? 1'b0 : 1'b1;
                    n_state = ST_MWR;
                end else begin
                    n_lo = s2;
                    n_state = ST_MNEXT;
                end
            end
            ST_MRDW: begin
                e_ra = o_rd;
                if (r_side) n_xj = o_rd; else n_xi = o_rd;
                n_state = ST_MCMP;
            end
            ST_MCMP: begin
                if (!r_side) begin
                    n_wi = e_rd[2*NodeW +: WB];
                    n_side = 1'b1;
                    n_state = ST_MRD;
                end else begin
                    o_we = 1'b1; o_wa = {~r_bank, EA'(r_k)};
                    n_k = r_k + 1'b1;
                    n_side = 1'b0;
                    if (r_wi >= e_rd[2*NodeW +: WB]) begin
                        o_wd = r_xi; n_i = r_i + 1'b1;
                    end else begin
                        o_wd = r_xj; n_j = r_j + 1'b1;
                    end
                    n_state = ST_MRD;
                end
            end
            ST_MWR: begin
                // tail copy: o_rd valid now
                o_we = 1'b1; o_wa = {~r_bank, EA'(r_k)}; o_wd = o_rd;
                n_k = r_k + 1'b1;
                if (r_side) n_j = r_j + 1'b1; else n_i = r_i + 1'b1;
                n_side = 1'b0;
                n_state = ST_MRD;
            end
            ST_KRD: begin
                if (r_k == r_ecnt) begin
                    n_state = ST_OUT;
                end else begin
                    o_ra = {r_bank, EA'(r_k)};
                    n_state = ST_KRDW;
                end
            end
            ST_KRDW: begin
                e_ra = o_rd;
                n_state = ST_KEDGE;
            end
            ST_KEDGE: begin
                n_ua = map_node(e_rd[NodeW-1:0], lim);
                n_ub = map_node(e_rd[2*NodeW-1:NodeW], lim);
                n_ew = e_rd[2*NodeW +: WB];
                n_cur = map_node(e_rd[NodeW-1:0], lim);
                n_phb = 1'b0; n_comp = 1'b0;
                n_state = ST_FRD;
            end
            ST_FRD: begin
                p_ra = r_cur;
                n_state = ST_FWAIT;
            end
            ST_FWAIT: begin
                n_state = ST_FCHK;
            end
            ST_FCHK: begin
                if (p_rd == r_cur) begin
                    n_root = r_cur;
                    n_cur  = r_phb ? r_ub : r_ua;
                    n_state = ST_CRD;
                end else begin
                    n_cur = p_rd;
                    n_state = ST_FRD;
                end
            end
            ST_CRD: begin
                p_ra = r_cur;
                n_state = ST_CWAIT;
            end
            ST_CWAIT: begin
                n_state = ST_CWR;
            end
            ST_CWR: begin
                if (p_rd == r_root || r_cur == r_root) begin
                    if (!r_phb) begin
                        n_ra = r_root; n_phb = 1'b1;
                        n_cur = r_ub; n_state = ST_FRD;
                    end else begin
                        n_state = ST_JOIN;
                    end
                end else begin
                    p_we = 1'b1; p_wa = r_cur; p_wd = r_root;
                    n_cur = p_rd;
                    n_state = ST_CRD;
                end
            end
            ST_JOIN: begin
                if (r_ra == r_root) begin
                    n_tot = (r_tot + (TotalW+1)'(r_ew) > (TotalW+1)'(TotalMax))
                          ? (TotalW+1)'(TotalMax) : r_tot + (TotalW+1)'(r_ew);
                    n_k = r_k + 1'b1;
                    n_state = ST_KRD;
                end else begin
                    z_ra = r_ra;
                    n_state = ST_SZRD;
                end
            end
            ST_SZRD: begin
                z_ra = r_root;
                n_sza = z_rd;
                n_state = ST_SZWAIT;
            end
            ST_SZWAIT: begin
                // keep the read on root b so z_rd holds its size
                z_ra = r_root;
                n_state = ST_SZWR;
            end
            ST_SZWR: begin
                // r_sza: size of root a, z_rd: size of root b
                p_we = 1'b1; z_we = 1'b1;
                z_wd = r_sza + z_rd;
                if (r_sza < z_rd) begin
                    p_wa = r_ra; p_wd = r_root; z_wa = r_root;
                end else begin
                    p_wa = r_root; p_wd = r_ra; z_wa = r_ra;
                end
                n_k = r_k + 1'b1;
                n_state = ST_KRD;
            end
            ST_OUT: begin
                n_state = ST_LOAD;
                n_ecnt = '0;
                n_tot = '0;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ncnt  <= NodeCountRst;
            r_ecnt  <= '0;
            r_tot   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ecnt  <= n_ecnt;
            r_tot   <= n_tot;
            if (i_cfg_valid && o_cfg_ready) r_ncnt <= i_cfg_data;
            if (r_state == ST_OUT) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ci <= n_ci; r_wid <= n_wid; r_bank <= n_bank; r_lo <= n_lo;
        r_i <= n_i; r_j <= n_j; r_k <= n_k; r_xi <= n_xi; r_xj <= n_xj;
        r_wi <= n_wi; r_side <= n_side; r_ua <= n_ua; r_ub <= n_ub;
        r_ew <= n_ew; r_phb <= n_phb; r_cur <= n_cur; r_root <= n_root;
        r_ra <= n_ra; r_comp <= n_comp; r_sza <= n_sza;
        if (r_state == ST_OUT) r_res <= r_tot[TotalW-1:0];
    end

endmodule : max_spanning_forest_leftover_weight
`default_nettype wire
